FILE: hw/rtl/ctwa_pkg.sv
// Shared types and constants for the centered time window average block.
// Used by ctwa_ring, ctwa_div and centered_time_window_average.
package ctwa_pkg;

  localparam int unsigned RING_DEPTH_DEF = 64;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned PWR_W  = 16;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned SUM_W  = 22;
  localparam int unsigned HALF_W = 16;
  localparam logic [HALF_W-1:0] HALF_RST = 16'd1500;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ORDER = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_CHK_W,
    S_EXT,
    S_EXT_W,
    S_SHR,
    S_SHR_W,
    S_DIV,
    S_DIV_W,
    S_STORE,
    S_PUSH,
    S_CLR,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] time_cs;
    logic [PWR_W-1:0]  power;
  } ring_entry_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_cs;
    logic [PWR_W-1:0]  mean;
    logic [CNT_W-1:0]  count;
    status_e           status;
  } result_t;

endpackage

FILE: hw/rtl/ctwa_ring.sv
// Sample ring: synchronous memory of time and power, one write and one
// registered read port. Depends on ctwa_pkg.
module ctwa_ring #(
  parameter int unsigned DEPTH = ctwa_pkg::RING_DEPTH_DEF,
  parameter int unsigned AW    = 6
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  ctwa_pkg::ring_entry_t wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output ctwa_pkg::ring_entry_t rdata_o
);

  ctwa_pkg::ring_entry_t mem [DEPTH];
  ctwa_pkg::ring_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/ctwa_div.sv
// Restoring divider, one quotient bit per cycle, for the window mean.
// Depends on ctwa_pkg.
module ctwa_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ctwa_pkg::SUM_W-1:0] dividend_i,
  input  logic [ctwa_pkg::CNT_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [ctwa_pkg::SUM_W-1:0] quotient_o
);

  localparam int unsigned SW = $clog2(ctwa_pkg::SUM_W + 1);

  logic                       busy_q;
  logic                       done_q;
  logic [SW-1:0]              step_q;
  logic [ctwa_pkg::SUM_W-1:0] quo_q;
  logic [ctwa_pkg::CNT_W-1:0] rem_q;
  logic [ctwa_pkg::CNT_W-1:0] div_q;
  logic [ctwa_pkg::CNT_W:0]   rem_shift;
  logic                       ge;

  assign rem_shift = {rem_q, quo_q[ctwa_pkg::SUM_W-1]};
  assign ge        = rem_shift >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == SW'(ctwa_pkg::SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[ctwa_pkg::SUM_W-2:0], ge};
      rem_q <= ge ? ctwa_pkg::CNT_W'(rem_shift - {1'b0, div_q})
                  : rem_shift[ctwa_pkg::CNT_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hw/rtl/centered_time_window_average.sv
// Top level of the centered time window average: control sequencer, window
// registers and output staging. Depends on ctwa_pkg, ctwa_ring, ctwa_div.
//
// Usage:
//   s_axis: one sample per transaction; tdata = {power_tenths, time_cs}
//   (time in bits 31:0), tlast = end_of_stream.
//   m_axis: zero or more results per sample; tdata = {pad, samples_in_window,
//   mean_power_tenths, sample_time_cs}, tuser = status, tlast = last_of_run.
//   cfg: one write of half_width_cs, taken only while the block is idle.
// A sample is taken while the block is idle; then the sequencer works on it
// alone: check, store and finish, a wait when a pending sample is checked and
// not ready, and per result its ready check, a read for each sample entering
// or leaving the window, the close of the two walks, a divide and a push; an
// end of stream adds a clear step.
// Memory reads and the divider set the rate.
// Results pass through a one-deep hold stage so the last one can be marked,
// then through an output register; a stalled m_axis holds the sequencer at
// its next push and the next sample waits.
// Reset clears the pointers, window sum and count, and sets half width 1500.
module centered_time_window_average #(
  parameter int unsigned RING_DEPTH = ctwa_pkg::RING_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // time_cs, power_tenths
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // sample_time_cs, mean_power_tenths, samples_in_window
  output logic [1:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned TW = ctwa_pkg::TIME_W;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  ctwa_pkg::state_e state_q, state_d;

  logic [TW-1:0]                t_in_q;
  logic [ctwa_pkg::PWR_W-1:0]   p_in_q;
  logic                         eos_q;
  logic                         flush_q;
  logic [TW-1:0]                prev_q;
  logic [PTR_W-1:0]             ws_q, end_q, pend_q, new_q;
  logic [ctwa_pkg::SUM_W-1:0]   sum_q;
  logic [ctwa_pkg::CNT_W-1:0]   cnt_q;
  logic [ctwa_pkg::HALF_W-1:0]  half_q;
  logic [TW-1:0]                cur_t_q;
  ctwa_pkg::result_t            res_q, hold_q, out_q;
  logic                         res_resolve_q;
  logic                         hold_v_q, out_v_q, out_last_q;

  ctwa_pkg::ring_entry_t        rdata, wdata;
  logic [PTR_W-1:0]             raddr;
  logic                         we;
  logic                         div_start, div_done;
  logic [ctwa_pkg::SUM_W-1:0]   quotient;

  logic                         in_acc, out_free, can_push, push, fin;
  logic [PTR_W:0]               held;
  logic                         full;
  logic [TW:0]                  half33;
  logic                         ready_hit, in_win, too_old;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_v_q || m_axis_tready;
  assign can_push = !hold_v_q || out_free;
  assign half33   = (TW + 1)'(half_q);

  assign held = (new_q >= ws_q) ? ({1'b0, new_q} - {1'b0, ws_q})
              : ({1'b0, new_q} + (PTR_W + 1)'(RING_DEPTH) - {1'b0, ws_q});
  assign full = held >= (PTR_W + 1)'(RING_DEPTH - 1);

  assign ready_hit = {1'b0, t_in_q} >= ({1'b0, rdata.time_cs} + half33);
  assign in_win    = {1'b0, rdata.time_cs} < ({1'b0, cur_t_q} + half33);
  assign too_old   = ({1'b0, rdata.time_cs} + half33) < {1'b0, cur_t_q};

  assign wdata.time_cs = t_in_q;
  assign wdata.power   = p_in_q;

  ctwa_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (PTR_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (new_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ctwa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ctwa_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (s_axis_tdata[TW-1:0] < prev_q) ? ctwa_pkg::S_PUSH : ctwa_pkg::S_CHK;
        end
      end
      ctwa_pkg::S_CHK: begin
        if (pend_q != new_q) state_d = ctwa_pkg::S_CHK_W;
        else                 state_d = flush_q ? ctwa_pkg::S_CLR : ctwa_pkg::S_STORE;
      end
      ctwa_pkg::S_CHK_W: begin
        state_d = (flush_q || ready_hit) ? ctwa_pkg::S_EXT : ctwa_pkg::S_STORE;
      end
      ctwa_pkg::S_EXT: begin
        state_d = (end_q != new_q) ? ctwa_pkg::S_EXT_W : ctwa_pkg::S_SHR;
      end
      ctwa_pkg::S_EXT_W: begin
        state_d = in_win ? ctwa_pkg::S_EXT : ctwa_pkg::S_SHR;
      end
      ctwa_pkg::S_SHR: begin
        state_d = (ws_q != end_q) ? ctwa_pkg::S_SHR_W : ctwa_pkg::S_DIV;
      end
      ctwa_pkg::S_SHR_W: begin
        state_d = too_old ? ctwa_pkg::S_SHR : ctwa_pkg::S_DIV;
      end
      ctwa_pkg::S_DIV: begin
        state_d = (cnt_q == '0) ? ctwa_pkg::S_PUSH : ctwa_pkg::S_DIV_W;
      end
      ctwa_pkg::S_DIV_W: begin
        if (div_done) state_d = ctwa_pkg::S_PUSH;
      end
      ctwa_pkg::S_STORE: begin
        if (full)       state_d = ctwa_pkg::S_PUSH;
        else if (eos_q) state_d = ctwa_pkg::S_CHK;
        else            state_d = ctwa_pkg::S_FIN;
      end
      ctwa_pkg::S_PUSH: begin
        if (can_push) begin
          state_d = (res_resolve_q || eos_q) ? ctwa_pkg::S_CHK : ctwa_pkg::S_FIN;
        end
      end
      ctwa_pkg::S_CLR: state_d = ctwa_pkg::S_FIN;
      ctwa_pkg::S_FIN: begin
        if (!hold_v_q || out_free) state_d = ctwa_pkg::S_IDLE;
      end
      default: state_d = ctwa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ctwa_pkg::S_IDLE);
    we            = (state_q == ctwa_pkg::S_STORE) && !full;
    div_start     = (state_q == ctwa_pkg::S_DIV) && (cnt_q != '0);
    push          = (state_q == ctwa_pkg::S_PUSH) && can_push;
    fin           = (state_q == ctwa_pkg::S_FIN) && (!hold_v_q || out_free);
    unique case (state_q)
      ctwa_pkg::S_EXT: raddr = end_q;
      ctwa_pkg::S_SHR: raddr = ws_q;
      default:         raddr = pend_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ctwa_pkg::S_IDLE;
      half_q   <= ctwa_pkg::HALF_RST;
      flush_q  <= 1'b0;
      prev_q   <= '0;
      ws_q     <= '0;
      end_q    <= '0;
      pend_q   <= '0;
      new_q    <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        half_q <= cfg_data_i;
      end
      if (in_acc) begin
        flush_q <= 1'b0;
        if (s_axis_tdata[TW-1:0] >= prev_q) begin
          prev_q <= s_axis_tdata[TW-1:0];
        end
      end
      if (state_q == ctwa_pkg::S_EXT_W && in_win) begin
        sum_q <= sum_q + ctwa_pkg::SUM_W'(rdata.power);
        cnt_q <= cnt_q + 1'b1;
        end_q <= ptr_inc(end_q);
      end
      if (state_q == ctwa_pkg::S_SHR_W && too_old) begin
        sum_q <= sum_q - ctwa_pkg::SUM_W'(rdata.power);
        cnt_q <= cnt_q - 1'b1;
        ws_q  <= ptr_inc(ws_q);
      end
      if (state_q == ctwa_pkg::S_STORE && !full) begin
        new_q <= ptr_inc(new_q);
        if (eos_q) flush_q <= 1'b1;
      end
      if (push) begin
        hold_v_q <= 1'b1;
        if (res_resolve_q) pend_q <= ptr_inc(pend_q);
        else if (eos_q)    flush_q <= 1'b1;
      end
      if (state_q == ctwa_pkg::S_CLR) begin
        ws_q   <= '0;
        end_q  <= '0;
        pend_q <= '0;
        new_q  <= '0;
        sum_q  <= '0;
        cnt_q  <= '0;
        prev_q <= '0;
      end
      if (fin) begin
        hold_v_q <= 1'b0;
      end
      if ((push || fin) && hold_v_q) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      t_in_q        <= s_axis_tdata[TW-1:0];
      p_in_q        <= s_axis_tdata[TW +: ctwa_pkg::PWR_W];
      eos_q         <= s_axis_tlast;
      res_q.time_cs <= s_axis_tdata[TW-1:0];
      res_q.mean    <= '0;
      res_q.count   <= '0;
      res_q.status  <= ctwa_pkg::ST_ORDER;
      res_resolve_q <= 1'b0;
    end
    if (state_q == ctwa_pkg::S_CHK_W) begin
      cur_t_q <= rdata.time_cs;
    end
    if (state_q == ctwa_pkg::S_DIV && cnt_q == '0) begin
      res_q.time_cs <= cur_t_q;
      res_q.mean    <= '0;
      res_q.count   <= '0;
      res_q.status  <= ctwa_pkg::ST_EMPTY;
      res_resolve_q <= 1'b1;
    end
    if (state_q == ctwa_pkg::S_DIV_W && div_done) begin
      res_q.time_cs <= cur_t_q;
      res_q.mean    <= quotient[ctwa_pkg::PWR_W-1:0];
      res_q.count   <= cnt_q;
      res_q.status  <= ctwa_pkg::ST_OK;
      res_resolve_q <= 1'b1;
    end
    if (state_q == ctwa_pkg::S_STORE && full) begin
      res_q.time_cs <= t_in_q;
      res_q.mean    <= '0;
      res_q.count   <= '0;
      res_q.status  <= ctwa_pkg::ST_FULL;
      res_resolve_q <= 1'b0;
    end
    if (push) begin
      hold_q <= res_q;
    end
    if ((push || fin) && hold_v_q) begin
      out_q      <= hold_q;
      out_last_q <= fin;
    end
  end

  assign cfg_ready_o   = (state_q == ctwa_pkg::S_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, out_q.count, out_q.mean, out_q.time_cs};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: sim/testbench.sv
// Testbench for centered_time_window_average: drives timestamped power samples
// and half-width settings, predicts every window mean and checks each result.
// Depends on ctwa_pkg and the centered_time_window_average RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned DEPTH = ctwa_pkg::RING_DEPTH_DEF;

  typedef struct packed {
    logic [31:0] time_cs;
    logic [15:0] power;
    logic        eos;
  } sample_t;

  typedef struct packed {
    logic [31:0]       time_cs;
    logic [15:0]       mean;
    logic [6:0]        count;
    ctwa_pkg::status_e status;
    logic              last;
  } avg_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  centered_time_window_average dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [31:0] ring_t [DEPTH];
  logic [15:0] ring_p [DEPTH];
  int unsigned win_start = 0, pend = 0, newest = 0, win_cnt = 0;
  logic [31:0] win_sum = '0, last_time = '0;
  logic [15:0] half_cs = ctwa_pkg::HALF_RST;

  sample_t     sample_q [$];
  avg_result_t expected_q [$];
  int          errors = 0;
  int          seen = 0;
  int          n_full = 0, n_order = 0, n_empty = 0;
  bit          in_taken = 1'b0;

  function automatic int unsigned nxt(int unsigned p);
    return (p + 1) % DEPTH;
  endfunction

  task automatic expect_result(logic [31:0] t, logic [15:0] m, logic [6:0] c,
                               ctwa_pkg::status_e s);
    avg_result_t r;
    r.time_cs = t; r.mean = m; r.count = c; r.status = s; r.last = 1'b0;
    expected_q.push_back(r);
  endtask

  task automatic close_window();
    logic [31:0] t;
    logic [32:0] hi;
    int unsigned e;
    t = ring_t[pend];
    hi = {1'b0, t} + half_cs;
    e = (win_start + win_cnt) % DEPTH;
    while (e != newest && {1'b0, ring_t[e]} < hi) begin
      win_sum += ring_p[e];
      win_cnt++;
      e = nxt(e);
    end
    while (win_start != e && {1'b0, ring_t[win_start]} + half_cs < {1'b0, t}) begin
      win_sum -= ring_p[win_start];
      win_cnt--;
      win_start = nxt(win_start);
    end
    if (win_cnt != 0) begin
      expect_result(t, 16'(win_sum / win_cnt), 7'(win_cnt), ctwa_pkg::ST_OK);
    end else begin
      expect_result(t, '0, '0, ctwa_pkg::ST_EMPTY);
    end
    pend = nxt(pend);
  endtask

  task automatic predict_average(sample_t s);
    int n_prior;
    n_prior = expected_q.size();
    if (s.time_cs < last_time) begin
      expect_result(s.time_cs, '0, '0, ctwa_pkg::ST_ORDER);
    end else begin
      last_time = s.time_cs;
      while (pend != newest && {1'b0, s.time_cs} >= {1'b0, ring_t[pend]} + half_cs)
        close_window();
      if ((newest + DEPTH - win_start) % DEPTH >= DEPTH - 1) begin
        expect_result(s.time_cs, '0, '0, ctwa_pkg::ST_FULL);
      end else begin
        ring_t[newest] = s.time_cs;
        ring_p[newest] = s.power;
        newest = nxt(newest);
      end
    end
    if (s.eos) begin
      while (pend != newest) close_window();
      win_start = 0; pend = 0; newest = 0; win_sum = 0; win_cnt = 0; last_time = 0;
    end
    if (expected_q.size() > n_prior) expected_q[$].last = 1'b1;
  endtask

  // record each accepted transaction at the edge that takes it
  always @(posedge clk_i) begin
    in_taken = 1'b0;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_average(sample_q.pop_front());
      in_taken = 1'b1;
    end
  end

  // sender: hold tvalid until the transaction completes
  int unsigned drv_gap = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_taken) begin
      s_axis_tvalid <= 1'b1;
    end else if (drv_gap != 0) begin
      drv_gap <= drv_gap - 1;
      s_axis_tvalid <= 1'b0;
    end else if (sample_q.size() != 0) begin
      s_axis_tdata <= {sample_q[0].power, sample_q[0].time_cs};
      s_axis_tlast <= sample_q[0].eos;
      s_axis_tvalid <= 1'b1;
      drv_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                 ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 80);
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  int unsigned rdy_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rdy_gap != 0) begin
        rdy_gap <= rdy_gap - 1;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 9) < 7) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        rdy_gap <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(20, 60);
      end
    end
  end

  always @(posedge clk_i) begin
    avg_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result time %0d", m_axis_tdata[31:0]);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tdata[31:0] !== e.time_cs) begin
          $error("sample_time_cs expected %0d actual %0d", e.time_cs, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[47:32] !== e.mean) begin
          $error("mean_power_tenths expected %0d actual %0d", e.mean, m_axis_tdata[47:32]);
          errors++;
        end
        if (m_axis_tdata[54:48] !== e.count) begin
          $error("samples_in_window expected %0d actual %0d", e.count, m_axis_tdata[54:48]);
          errors++;
        end
        if (m_axis_tuser !== e.status) begin
          $error("status expected %0d actual %0d", e.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last_of_run expected %0d actual %0d", e.last, m_axis_tlast);
          errors++;
        end
        if (e.status == ctwa_pkg::ST_FULL) n_full++;
        if (e.status == ctwa_pkg::ST_ORDER) n_order++;
        if (e.status == ctwa_pkg::ST_EMPTY) n_empty++;
      end
    end
  end

  task automatic add_sample(logic [31:0] t, logic [15:0] p, logic e);
    sample_t s;
    s.time_cs = t; s.power = p; s.eos = e;
    sample_q.push_back(s);
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_half(logic [15:0] v);
    @(negedge clk_i);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    half_cs = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one run of well-formed samples with some noise, ending in a flush unless its last sample is noise
  task automatic random_run(int len, int step_max);
    logic [31:0] t;
    t = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 100000);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0)
        add_sample(t - $urandom_range(1, 50), 16'($urandom), 1'b0);
      else begin
        t = (t > 32'hFFFF_0000) ? t : t + $urandom_range(0, step_max);
        add_sample(t, 16'($urandom), i == len - 1);
      end
    end
  endtask

  initial begin
    logic [15:0] halves [5];
    int sent;
    halves = '{16'd0, 16'd65535, 16'd1, 16'd300, 16'd100};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: default half width, extremes, reorder, flush
    add_sample(32'd0, 16'd0, 1'b0);
    add_sample(32'd0, 16'hFFFF, 1'b0);
    add_sample(32'd1000, 16'hFFFF, 1'b0);
    add_sample(32'd999, 16'd5, 1'b0);
    add_sample(32'd3000, 16'd123, 1'b0);
    add_sample(32'd6000, 16'd7, 1'b1);
    add_sample(32'hFFFF_FFF0, 16'hAAAA, 1'b0);
    add_sample(32'hFFFF_FFFF, 16'h5555, 1'b0);
    add_sample(32'd10, 16'd1, 1'b1);
    drain();

    // ring full: 70 samples at the same time
    for (int i = 0; i < 70; i++) add_sample(32'd500, 16'($urandom), i == 69);
    drain();

    sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      write_half(halves[ph]);
      if (ph == 0) begin
        add_sample(32'd5, 16'd9, 1'b0);
        add_sample(32'd5, 16'd3, 1'b0);
        add_sample(32'd6, 16'd4, 1'b1);
      end
      while (sent < 22 * (ph + 1)) begin
        int len;
        len = $urandom_range(0, 9) == 0 ? $urandom_range(40, 70) : $urandom_range(1, 12);
        random_run(len, ph == 1 ? 2000 : 3 * halves[ph] + 5);
        sent += len;
      end
      drain();
    end
    write_half(ctwa_pkg::HALF_RST);
    random_run(8, 4000);
    drain();

    $display("covered %0d results: %0d ring-full, %0d out-of-order, %0d empty-window",
             seen, n_full, n_order, n_empty);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ctwa_pkg.sv
hw/rtl/ctwa_ring.sv
hw/rtl/ctwa_div.sv
hw/rtl/centered_time_window_average.sv
sim/testbench.sv
